/* design/gshare_branch_predictor_assert.svh */
// Assertion macros shared by the gshare predictor RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef GSHARE_BRANCH_PREDICTOR_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_ASSERT_SVH

// Clocked check, masked while reset is high
`define GBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define GBP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/gbp_pkg.sv */
// Shared constants and types of the gshare branch predictor.
// No dependencies; imported by every predictor module but gbp_ram.
package gbp_pkg;

   localparam int MAX_INDEX_BITS = 12;
   localparam int TOTAL_WIDTH    = 32;
   localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
   localparam int CFG_WIDTH      = 4;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int OUT_WIDTH      = 32;
   localparam int ADDR_WIDTH     = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INDEX_BITS   = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HISTORY_BITS = CSR_IDX_WIDTH'(1);

   // Reset values of the configuration registers
   localparam logic [CFG_WIDTH-1:0] INDEX_BITS_RESET   = CFG_WIDTH'(8);
   localparam logic [CFG_WIDTH-1:0] HISTORY_BITS_RESET = CFG_WIDTH'(5);

   // Two-bit counter codes
   localparam logic [1:0] CNT_STRONG_NOT   = 2'd0;
   localparam logic [1:0] CNT_WEAK_TAKEN   = 2'd2;
   localparam logic [1:0] CNT_STRONG_TAKEN = 2'd3;

   typedef logic [MAX_INDEX_BITS-1:0] index_type;
   typedef logic [TOTAL_WIDTH-1:0]    total_type;

   // Outcome of one resolved branch, handed to the statistics unit
   typedef struct packed {
      logic update;
      logic miss;
   } outcome_type;

endpackage

/* design/gshare_branch_predictor.sv */
// Channel  | Direction | Handshake         | Payload
// req      | in        | req_valid/stall   | req_branch_addr, req_taken
// rsp      | out       | rsp_valid/stall   | rsp_predicted_taken, rsp_mispredicted,
//          |           |                   | rsp_hit_total, rsp_miss_total
// csr      | in        | csr_write_enable  | csr_index, csr_write_data
//
// One branch per cycle sustained while rsp is not stalled; each branch passes
// the counter RAM read, then training and the output register.
// After reset a clearing pass writes all 4096 counters to weakly taken, one a
// cycle, during which req_stall stays high; csr writes are taken as ever.
// A stalled result holds the training stage, which then stalls req.
// Depends on gbp_pkg, gbp_ram, gbp_index, gbp_stats.
`include "gshare_branch_predictor_assert.svh"
module gshare_branch_predictor
   import gbp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ADDR_WIDTH-1:0]    req_branch_addr,
   input  logic                     req_taken,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_predicted_taken,
   output logic                     rsp_mispredicted,
   output logic [OUT_WIDTH-1:0]     rsp_hit_total,
   output logic [OUT_WIDTH-1:0]     rsp_miss_total,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_write_data
);

   logic        req_accept;
   index_type   req_index;
   logic        clear_active_ff;
   index_type   clear_addr_ff;
   logic        s1_valid_ff;
   index_type   s1_idx_ff;
   logic        s1_taken_ff;
   logic        s1_advance;
   logic [1:0]  rd_cnt;
   logic [1:0]  cur_cnt;
   logic [1:0]  new_cnt;
   logic        pred;
   logic        miss;
   logic        wr_valid_ff;
   index_type   wr_idx_ff;
   logic [1:0]  wr_cnt_ff;
   logic        ram_wr_en;
   index_type   ram_wr_addr;
   logic [1:0]  ram_wr_data;
   logic        rsp_valid_ff;
   logic        rsp_pred_ff;
   logic        rsp_miss_ff;
   outcome_type outcome;
   total_type   hit_count;
   total_type   miss_count;

   // Handshake control
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clear_active_ff || (s1_valid_ff && !s1_advance);
   assign req_accept = req_valid && !req_stall;

   gbp_index u_index (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (req_accept),
      .branch_addr      (req_branch_addr),
      .taken            (req_taken),
      .index            (req_index)
   );

   // Clearing pass over the counter table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else if (clear_active_ff) begin
         clear_addr_ff <= clear_addr_ff + MAX_INDEX_BITS'(1);
         if (clear_addr_ff == index_type'(TABLE_DEPTH - 1)) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   // Write mux: clearing pass, else the trained counter
   always_comb begin
      if (clear_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = CNT_WEAK_TAKEN;
      end else begin
         ram_wr_en   = s1_advance;
         ram_wr_addr = s1_idx_ff;
         ram_wr_data = new_cnt;
      end
   end

   gbp_ram #(
      .WIDTH (2),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_index),
      .rd_data (rd_cnt)
   );

   // Training stage: hold the branch while its counter is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_idx_ff   <= req_index;
         s1_taken_ff <= req_taken;
      end
   end

   // Last trained counter, forwarded over a read that missed its write
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         wr_idx_ff <= s1_idx_ff;
         wr_cnt_ff <= new_cnt;
      end
   end

   // Predict and train the two-bit counter
   always_comb begin
      cur_cnt = (wr_valid_ff && wr_idx_ff == s1_idx_ff) ? wr_cnt_ff : rd_cnt;
      pred    = cur_cnt[1];
      miss    = pred ^ s1_taken_ff;
      new_cnt = cur_cnt;
      if (s1_taken_ff) begin
         if (cur_cnt != CNT_STRONG_TAKEN) begin
            new_cnt = cur_cnt + 2'd1;
         end
      end else begin
         if (cur_cnt != CNT_STRONG_NOT) begin
            new_cnt = cur_cnt - 2'd1;
         end
      end
   end

   assign outcome.update = s1_advance;
   assign outcome.miss   = miss;

   gbp_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .outcome    (outcome),
      .hit_count  (hit_count),
      .miss_count (miss_count)
   );

   // Output register; totals change only when a new result loads
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_pred_ff <= pred;
         rsp_miss_ff <= miss;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_mispredicted    = rsp_miss_ff;
   assign rsp_hit_total       = OUT_WIDTH'(hit_count);
   assign rsp_miss_total      = OUT_WIDTH'(miss_count);

   `GBP_ASSERT(a_clear_blocks, clock, reset,
      clear_active_ff |-> req_stall && !s1_valid_ff,
      "branch accepted during the clearing pass")
   `GBP_ASSERT(a_advance_shows, clock, reset,
      s1_advance |=> rsp_valid_ff,
      "trained branch produced no result")
   `GBP_ASSERT(a_stage_holds, clock, reset,
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_idx_ff),
      "held branch lost its table index")
   `GBP_ASSERT(a_totals_hold, clock, reset,
      rsp_valid_ff && rsp_stall |=> $stable(rsp_hit_total) && $stable(rsp_miss_total),
      "totals moved under a held result")

endmodule

/* design/gbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write; hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gbp_index.sv */
// Configuration registers, global history and table index hashing.
// Depends on gbp_pkg.
module gbp_index
   import gbp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_write_data,
   input  logic                     accept,
   input  logic [ADDR_WIDTH-1:0]    branch_addr,
   input  logic                     taken,
   output index_type                index
);

   logic [CFG_WIDTH-1:0] index_bits_ff;
   logic [CFG_WIDTH-1:0] history_bits_ff;
   index_type            history_ff;
   index_type            history_in;
   logic [CFG_WIDTH-1:0] m_eff;
   logic [CFG_WIDTH-1:0] n_eff;
   index_type            m_mask;
   index_type            n_mask;
   index_type            hist_used;
   index_type            addr_part;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff   <= INDEX_BITS_RESET;
         history_bits_ff <= HISTORY_BITS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INDEX_BITS:   index_bits_ff   <= csr_write_data;
            CSR_HISTORY_BITS: history_bits_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Clamp the widths: index 1..MAX, history 0..index
   always_comb begin
      if (index_bits_ff == '0) begin
         m_eff = CFG_WIDTH'(1);
      end else if (index_bits_ff > CFG_WIDTH'(MAX_INDEX_BITS)) begin
         m_eff = CFG_WIDTH'(MAX_INDEX_BITS);
      end else begin
         m_eff = index_bits_ff;
      end
      n_eff = (history_bits_ff > m_eff) ? m_eff : history_bits_ff;
   end

   // Hash the word address with the history placed at the top of the index
   always_comb begin
      m_mask    = ~({MAX_INDEX_BITS{1'b1}} << m_eff);
      n_mask    = ~({MAX_INDEX_BITS{1'b1}} << n_eff);
      hist_used = history_ff & n_mask;
      addr_part = branch_addr[MAX_INDEX_BITS+1:2] & m_mask;
      if (n_eff != '0) begin
         index = addr_part ^ ((hist_used << (m_eff - n_eff)) & m_mask);
      end else begin
         index = addr_part;
      end
   end

   // Shift the outcome into the top used history bit
   always_comb begin
      history_in = history_ff;
      if (n_eff != '0) begin
         history_in = (hist_used >> 1)
                    | (MAX_INDEX_BITS'(taken) << (n_eff - CFG_WIDTH'(1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (accept) begin
         history_ff <= history_in;
      end
   end

endmodule

/* design/gbp_stats.sv */
// Saturating hit and miss totals.
// Depends on gbp_pkg.
`include "gshare_branch_predictor_assert.svh"
module gbp_stats
   import gbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  outcome_type outcome,
   output total_type   hit_count,
   output total_type   miss_count
);

   total_type hit_count_ff;
   total_type miss_count_ff;

   // Count each resolved branch once, holding at the top value
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
      end else if (outcome.update) begin
         if (outcome.miss) begin
            if (miss_count_ff != '1) begin
               miss_count_ff <= miss_count_ff + TOTAL_WIDTH'(1);
            end
         end else begin
            if (hit_count_ff != '1) begin
               hit_count_ff <= hit_count_ff + TOTAL_WIDTH'(1);
            end
         end
      end
   end

   assign hit_count  = hit_count_ff;
   assign miss_count = miss_count_ff;

   `GBP_ASSERT(a_idle_hold, clock, reset,
      !outcome.update |=> $stable(hit_count_ff) && $stable(miss_count_ff),
      "totals changed without a resolved branch")
   `GBP_ASSERT(a_one_total, clock, reset,
      outcome.update |=> $stable(hit_count_ff) || $stable(miss_count_ff),
      "both totals changed for one branch")
   `GBP_ASSERT(a_miss_counts, clock, reset,
      outcome.update && outcome.miss && miss_count_ff != '1
         |=> miss_count_ff == $past(miss_count_ff) + TOTAL_WIDTH'(1),
      "miss total did not advance")

endmodule
